// ===== hw/rtl/rllt_pkg.sv =====
`default_nettype none

package rllt_pkg;

    localparam int LINE_W  = 16;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int OFF_W   = 12;
    localparam int STAT_W  = 2;
    localparam int BCNT_W  = 13;
    localparam int RUN_W   = LINE_W + COUNT_W;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic REG_LINE_INFO = 1'b0;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CMP
    } t_state;

    typedef struct packed {
        logic [LINE_W-1:0] line_result;
        t_status           status;
        logic [BCNT_W-1:0] bytes_stored;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/rllt_ram.sv =====
`default_nettype none

module rllt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/rllt_engine.sv =====
`default_nettype none

module rllt_engine #(
    parameter int CODE_DEPTH = 4096,
    parameter int RUN_DEPTH  = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_line_info_enable,
    input  wire logic                          i_start,
    input  wire logic                          i_operation,
    input  wire logic [rllt_pkg::BYTE_W-1:0]   i_code_byte,
    input  wire logic [rllt_pkg::LINE_W-1:0]   i_source_line,
    input  wire logic [rllt_pkg::OFF_W-1:0]    i_byte_offset,
    output logic                               o_busy,
    output logic                               o_done,
    output rllt_pkg::t_result                  o_res,
    output logic                               o_code_we,
    output logic [$clog2(CODE_DEPTH)-1:0]      o_code_addr,
    output logic [rllt_pkg::BYTE_W-1:0]        o_code_data,
    output logic                               o_run_we,
    output logic [$clog2(RUN_DEPTH)-1:0]       o_run_addr,
    output logic [rllt_pkg::RUN_W-1:0]         o_run_wr_data,
    input  wire logic [rllt_pkg::RUN_W-1:0]    i_run_rd_data
);

    import rllt_pkg::*;

    localparam int CAW = $clog2(CODE_DEPTH);
    localparam int CW  = $clog2(CODE_DEPTH + 1);
    localparam int RW  = $clog2(RUN_DEPTH);
    localparam int WW  = (CW + 1 > 17) ? CW + 1 : 17;

    t_state r_state, n_state;

    logic               r_op;
    logic [BYTE_W-1:0]  r_byte;
    logic [LINE_W-1:0]  r_line;
    logic [OFF_W-1:0]   r_off;

    logic [CW-1:0]      r_byte_count, n_byte_count;
    logic [RW-1:0]      r_cur_run, n_cur_run;
    logic [LINE_W-1:0]  r_cur_line, n_cur_line;
    logic [COUNT_W-1:0] r_cur_count, n_cur_count;
    logic [RW-1:0]      r_idx, n_idx;
    logic [WW-1:0]      r_acc, n_acc;
    t_result            r_res, n_res;
    logic               r_done, n_done;

    logic               code_full;
    logic               open_new;
    logic               run_full;
    logic [RW-1:0]      app_run;
    logic [COUNT_W-1:0] app_count;
    logic [LINE_W-1:0]  sel_line;
    logic [COUNT_W-1:0] sel_count;
    logic [WW-1:0]      span_end;
    logic [WW-1:0]      off_w;

    assign off_w     = WW'(r_off);
    assign code_full = (r_byte_count >= CW'(CODE_DEPTH));
    assign open_new  = i_line_info_enable && (r_cur_line != '0) && (r_cur_line != r_line);
    assign run_full  = open_new && (r_cur_run == RW'(RUN_DEPTH - 1));
    assign app_run   = open_new ? r_cur_run + RW'(1) : r_cur_run;
    assign app_count = open_new ? COUNT_W'(1) : r_cur_count + COUNT_W'(1);

    // the current run lives in the cache; the memory copy may still be unwritten
    assign sel_line  = (r_idx == r_cur_run) ? r_cur_line  : i_run_rd_data[RUN_W-1:COUNT_W];
    assign sel_count = (r_idx == r_cur_run) ? r_cur_count : i_run_rd_data[COUNT_W-1:0];
    // a run covers at least one offset, even when its count wrapped to zero
    assign span_end  = r_acc + ((sel_count == '0) ? WW'(1) : WW'(sel_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_byte_count <= '0;
            r_cur_run    <= '0;
            r_cur_line   <= '0;
            r_cur_count  <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_cur_run    <= n_cur_run;
            r_cur_line   <= n_cur_line;
            r_cur_count  <= n_cur_count;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state == S_IDLE) begin
            r_op   <= i_operation;
            r_byte <= i_code_byte;
            r_line <= i_source_line;
            r_off  <= i_byte_offset;
        end
        r_idx <= n_idx;
        r_acc <= n_acc;
        r_res <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_cur_run    = r_cur_run;
        n_cur_line   = r_cur_line;
        n_cur_count  = r_cur_count;
        n_idx        = r_idx;
        n_acc        = r_acc;
        n_res        = r_res;
        n_done       = 1'b0;
        o_code_we    = 1'b0;
        o_run_we     = 1'b0;
        o_run_addr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state            = S_IDLE;
                n_done             = 1'b1;
                n_res.line_result  = '0;
                n_res.status       = ST_OK;
                if (r_op == OP_APPEND) begin
                    if (code_full || run_full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        o_code_we    = 1'b1;
                        n_byte_count = r_byte_count + CW'(1);
                        if (i_line_info_enable) begin
                            o_run_we    = 1'b1;
                            o_run_addr  = app_run;
                            n_cur_run   = app_run;
                            n_cur_line  = r_line;
                            n_cur_count = app_count;
                        end
                    end
                    n_res.bytes_stored = BCNT_W'(n_byte_count);
                end else begin
                    n_res.bytes_stored = BCNT_W'(r_byte_count);
                    if (off_w >= WW'(r_byte_count)) begin
                        n_res.status = ST_RANGE;
                    end else if (i_line_info_enable) begin
                        // walk the runs from the first
                        n_state = S_READ;
                        n_done  = 1'b0;
                        n_idx   = '0;
                        n_acc   = '0;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (off_w < span_end) begin
                    n_state           = S_IDLE;
                    n_done            = 1'b1;
                    n_res.line_result = sel_line;
                end else if (r_idx == r_cur_run) begin
                    n_state           = S_IDLE;
                    n_done            = 1'b1;
                    n_res.line_result = '0;
                end else begin
                    n_state = S_READ;
                    n_idx   = r_idx + RW'(1);
                    n_acc   = span_end;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_code_addr   = r_byte_count[CAW-1:0];
    assign o_code_data   = r_byte;
    assign o_run_wr_data = {r_line, app_count};
    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_res         = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/run_length_line_table_core.sv =====
`default_nettype none

// Code byte store with a run-length line table. Raise start while busy is low to hand in
// one item; its single result appears on the o_ result ports for exactly one cycle with
// o_result_valid high, and the receiver cannot stall it, so it must take it then. An
// append (and any lookup answered out of range or with line info disabled) passes
// through the single S_EXEC state, in which busy is high; the next item can be accepted
// at the edge at which its result is taken. A lookup that walks the table keeps busy high
// through S_EXEC, then an S_READ and an S_CMP state for each of n runs, n being the number
// visited up to the one covering the offset, or up to the last run when the runs do not
// reach it: the run memory has one port with a registered read, and a single adder and
// compare step through the runs one at a time. line_info_enable is register 0 at
// address 0 and is to be written only while the block is idle.
module run_length_line_table_core #(
    parameter int CODE_DEPTH = 4096,
    parameter int RUN_DEPTH  = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [rllt_pkg::BYTE_W-1:0]   i_code_byte,
    input  wire logic [rllt_pkg::LINE_W-1:0]   i_source_line,
    input  wire logic [rllt_pkg::OFF_W-1:0]    i_byte_offset,
    output logic                               o_result_valid,
    output logic [rllt_pkg::LINE_W-1:0]        o_line_result,
    output logic [rllt_pkg::STAT_W-1:0]        o_status,
    output logic [rllt_pkg::BCNT_W-1:0]        o_bytes_stored
);

    import rllt_pkg::*;

    localparam int CAW = $clog2(CODE_DEPTH);
    localparam int RW  = $clog2(RUN_DEPTH);

    logic               r_line_info_enable;
    logic               reg_hit;
    t_result            res;
    logic               code_we;
    logic [CAW-1:0]     code_addr;
    logic [BYTE_W-1:0]  code_data;
    logic               run_we;
    logic [RW-1:0]      run_addr;
    logic [RUN_W-1:0]   run_wr_data;
    logic [RUN_W-1:0]   run_rd_data;

    assign reg_hit = (paddr[2] == REG_LINE_INFO);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {31'b0, r_line_info_enable} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_info_enable <= 1'b1;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_line_info_enable <= pwdata[0];
        end
    end

    rllt_engine #(
        .CODE_DEPTH (CODE_DEPTH),
        .RUN_DEPTH  (RUN_DEPTH)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_line_info_enable (r_line_info_enable),
        .i_start            (start),
        .i_operation        (i_operation),
        .i_code_byte        (i_code_byte),
        .i_source_line      (i_source_line),
        .i_byte_offset      (i_byte_offset),
        .o_busy             (busy),
        .o_done             (o_result_valid),
        .o_res              (res),
        .o_code_we          (code_we),
        .o_code_addr        (code_addr),
        .o_code_data        (code_data),
        .o_run_we           (run_we),
        .o_run_addr         (run_addr),
        .o_run_wr_data      (run_wr_data),
        .i_run_rd_data      (run_rd_data)
    );

    // code bytes are only stored here, never read back
    rllt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CODE_DEPTH)
    ) u_code_ram (
        .i_clk     (i_clk),
        .i_we      (code_we),
        .i_addr    (code_addr),
        .i_wr_data (code_data),
        .o_rd_data ()
    );

    rllt_ram #(
        .WIDTH (RUN_W),
        .DEPTH (RUN_DEPTH)
    ) u_run_ram (
        .i_clk     (i_clk),
        .i_we      (run_we),
        .i_addr    (run_addr),
        .i_wr_data (run_wr_data),
        .o_rd_data (run_rd_data)
    );

    assign o_line_result  = res.line_result;
    assign o_status       = res.status;
    assign o_bytes_stored = res.bytes_stored;

endmodule

`default_nettype wire
